[rtl/circular_list_cursor_engine_defines.svh]
// ---------------------------------------------------------------------------
// circular list cursor engine assertion macros
// shared shorthands for the clocked checks, sampled on aclk, off in reset
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_CURSOR_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_CURSOR_ENGINE_DEFINES_SVH

// plain clocked property
`define CLCE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// same-cycle implication
`define CLCE_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/clce_pkg.sv]
// ---------------------------------------------------------------------------
// clce_pkg
// shared constants, types and helpers of the circular list cursor engine
// ---------------------------------------------------------------------------
package clce_pkg;

    localparam int POOL_DEPTH  = 256;
    localparam int PTR_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
    localparam int VALUE_WIDTH = 32;

    // fixed field widths of the stream words
    localparam int MODE_W    = 3;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - 1 - DATA_W - COUNT_W;

    typedef enum logic [MODE_W-1:0] {
        OP_INS_HEAD  = 3'd0,
        OP_INS_TAIL  = 3'd1,
        OP_CUR_FIRST = 3'd2,
        OP_CUR_NEXT  = 3'd3,
        OP_DELETE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd;
        logic ex;
        logic fin;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // sign-adjust input data into node value width
    function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [DATA_W-1:0] d);
        logic [63:0] w;
        w = 64'($signed(d));
        return w[VALUE_WIDTH-1:0];
    endfunction

    // sign-adjust node value into output data width
    function automatic logic [DATA_W-1:0] from_value(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'($signed(v));
        return w[DATA_W-1:0];
    endfunction

endpackage

[rtl/circular_list_cursor_engine.sv]
// ---------------------------------------------------------------------------
// circular_list_cursor_engine
// circular singly linked list with a traversal cursor over a fixed node pool
// ---------------------------------------------------------------------------
// result: the result word is registered in the finish step, after the read and execute steps,
//   and finish waits only while the previous result word is still unread
// flow: a new word is taken only after the previous one has run the read / execute / finish
//   sequence through the single read port of the link memory
// reset: synchronous active-low; list empty, every slot free, no clearing pass
//   (never-used slots are handed out by a low-water counter)
// ---------------------------------------------------------------------------
module circular_list_cursor_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel: one operation per word
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [clce_pkg::S_TDATA_W-1:0]  s_tdata,   // mode[2:0], data_in[34:3], zero pad
    // result channel: one result per operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [clce_pkg::M_TDATA_W-1:0]  m_tdata    // ok[0], value_out[32:1], count[41:33]
);

    import clce_pkg::*;

    // command and status between sequencer and datapath
    ctl_cmd_t   cmd;
    dp_status_t status;

    // sequencer: takes a word only when idle, then steps read, execute, finish;
    // finish waits for the result register to free up
    clce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: value, link and free-slot memories, tail / cursor / before
    // pointers, node count and the output register that decouples the
    // result channel from the next operation
    clce_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[rtl/clce_ram.sv]
// ---------------------------------------------------------------------------
// clce_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module clce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/clce_ctrl.sv]
// ---------------------------------------------------------------------------
// clce_ctrl
// sequencer: accept, read, execute, finish for every operation
// ---------------------------------------------------------------------------
module clce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  clce_pkg::dp_status_t  status,
    output clce_pkg::ctl_cmd_t    cmd
);

    import clce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.ex     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold here while the previous result word is still unread
                if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/clce_datapath.sv]
// ---------------------------------------------------------------------------
// clce_datapath
// node memories, free-slot stack, list pointers and the result register
// ---------------------------------------------------------------------------
`include "circular_list_cursor_engine_defines.svh"

module clce_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  clce_pkg::ctl_cmd_t              cmd,
    output clce_pkg::dp_status_t            status,
    input  logic [clce_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [clce_pkg::M_TDATA_W-1:0]  m_tdata
);

    import clce_pkg::*;

    logic [MODE_W-1:0]      op_reg,     op_next;
    logic [VALUE_WIDTH-1:0] data_reg,   data_next;
    logic [PTR_W-1:0]       tail_reg,   tail_next;
    logic [PTR_W-1:0]       cursor_reg, cursor_next;
    logic [PTR_W-1:0]       before_reg, before_next;
    logic [PTR_W-1:0]       slot_reg,   slot_next;
    logic [PTR_W-1:0]       succ_reg,   succ_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [CNT_W-1:0]       fresh_reg,  fresh_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,  m_tdata_next;

    logic                   val_wr_en, val_rd_en;
    logic [PTR_W-1:0]       val_wr_addr, val_rd_addr;
    logic [VALUE_WIDTH-1:0] val_rd_data;
    logic                   link_wr_en, link_rd_en;
    logic [PTR_W-1:0]       link_wr_addr, link_wr_data, link_rd_addr, link_rd_data;
    logic                   free_wr_en, free_rd_en;
    logic [PTR_W-1:0]       free_wr_addr, free_rd_addr, free_rd_data;

    logic [CNT_W-1:0]       pop_pos, push_pos;
    logic [PTR_W-1:0]       new_slot;
    logic                   full, empty, single;
    logic                   res_ok;
    logic [VALUE_WIDTH-1:0] res_val;

    assign full   = (count_reg == CNT_W'(POOL_DEPTH));
    assign empty  = (count_reg == '0);
    assign single = (count_reg == CNT_W'(1));

    // stack top sits at pool depth minus one minus count
    assign pop_pos  = CNT_W'(POOL_DEPTH - 1) - count_reg;
    assign push_pos = CNT_W'(POOL_DEPTH) - count_reg;

    // while the count equals the low-water mark no freed slot waits on the stack,
    // so the new slot is the next never-used slot index, the count itself
    assign new_slot = (count_reg == fresh_reg) ? count_reg[PTR_W-1:0] : free_rd_data;

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg     <= '0;
            cursor_reg   <= '0;
            before_reg   <= '0;
            count_reg    <= '0;
            fresh_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            tail_reg     <= tail_next;
            cursor_reg   <= cursor_next;
            before_reg   <= before_next;
            count_reg    <= count_next;
            fresh_reg    <= fresh_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        data_reg    <= data_next;
        slot_reg    <= slot_next;
        succ_reg    <= succ_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        op_next       = op_reg;
        data_next     = data_reg;
        tail_next     = tail_reg;
        cursor_next   = cursor_reg;
        before_next   = before_reg;
        slot_next     = slot_reg;
        succ_next     = succ_reg;
        count_next    = count_reg;
        fresh_next    = fresh_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        val_wr_en     = 1'b0;
        val_wr_addr   = slot_reg;
        val_rd_en     = 1'b0;
        val_rd_addr   = cursor_reg;
        link_wr_en    = 1'b0;
        link_wr_addr  = tail_reg;
        link_wr_data  = slot_reg;
        link_rd_en    = 1'b0;
        link_rd_addr  = tail_reg;
        free_wr_en    = 1'b0;
        free_wr_addr  = push_pos[PTR_W-1:0];
        free_rd_en    = 1'b0;
        free_rd_addr  = pop_pos[PTR_W-1:0];
        res_ok        = 1'b0;
        res_val       = '0;

        if (cmd.capture) begin
            op_next   = s_tdata[MODE_W-1:0];
            data_next = to_value(s_tdata[MODE_W +: DATA_W]);
        end

        // first step: fetch free slot, successor link and cursor value
        if (cmd.rd) begin
            free_rd_en = 1'b1;
            link_rd_en = 1'b1;
            val_rd_en  = 1'b1;
            if (op_reg == OP_CUR_NEXT || op_reg == OP_DELETE) begin
                link_rd_addr = cursor_reg;
            end
        end

        // second step: place a new node, or fetch the value at the new cursor
        if (cmd.ex) begin
            case (op_reg)
                OP_INS_HEAD, OP_INS_TAIL: begin
                    if (!full) begin
                        slot_next    = new_slot;
                        val_wr_en    = 1'b1;
                        val_wr_addr  = new_slot;
                        link_wr_en   = 1'b1;
                        link_wr_addr = new_slot;
                        link_wr_data = empty ? new_slot : link_rd_data;
                    end
                end
                OP_CUR_FIRST, OP_CUR_NEXT: begin
                    if (!empty) begin
                        succ_next   = link_rd_data;
                        val_rd_en   = 1'b1;
                        val_rd_addr = link_rd_data;
                    end
                end
                default: begin
                end
            endcase
        end

        // last step: relink, move pointers, build the result word
        if (cmd.fin) begin
            case (op_reg)
                OP_INS_HEAD, OP_INS_TAIL: begin
                    if (!full) begin
                        res_ok     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_reg == fresh_reg) begin
                            fresh_next = fresh_reg + 1'b1;
                        end
                        if (empty) begin
                            tail_next   = slot_reg;
                            cursor_next = slot_reg;
                            before_next = slot_reg;
                        end else begin
                            link_wr_en = 1'b1;
                            if (tail_reg == before_reg) begin
                                before_next = slot_reg;
                            end
                            if (op_reg == OP_INS_TAIL) begin
                                tail_next = slot_reg;
                            end
                        end
                    end
                end
                OP_CUR_FIRST: begin
                    if (!empty) begin
                        res_ok      = 1'b1;
                        res_val     = val_rd_data;
                        cursor_next = succ_reg;
                        before_next = tail_reg;
                    end
                end
                OP_CUR_NEXT: begin
                    if (!empty) begin
                        res_ok      = 1'b1;
                        res_val     = val_rd_data;
                        cursor_next = succ_reg;
                        before_next = cursor_reg;
                    end
                end
                OP_DELETE: begin
                    if (single) begin
                        res_ok       = 1'b1;
                        res_val      = val_rd_data;
                        free_wr_en   = 1'b1;
                        free_wr_addr = push_pos[PTR_W-1:0];
                        tail_next    = '0;
                        cursor_next  = '0;
                        before_next  = '0;
                        count_next   = '0;
                    end else if (!empty) begin
                        // cursor is the victim; before keeps its place
                        res_ok       = 1'b1;
                        res_val      = val_rd_data;
                        free_wr_en   = 1'b1;
                        link_wr_en   = 1'b1;
                        link_wr_addr = before_reg;
                        link_wr_data = link_rd_data;
                        cursor_next  = link_rd_data;
                        count_next   = count_reg - 1'b1;
                        if (cursor_reg == tail_reg) begin
                            tail_next = before_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, COUNT_W'(count_next),
                             from_value(res_val), res_ok};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    clce_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (data_reg),
        .rd_en   (val_rd_en),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    clce_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    clce_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_DEPTH)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (free_wr_en),
        .wr_addr (free_wr_addr),
        .wr_data (cursor_reg),
        .rd_en   (free_rd_en),
        .rd_addr (free_rd_addr),
        .rd_data (free_rd_data)
    );

    `CLCE_ASSERT(a_fresh_covers_count, fresh_reg >= count_reg, "more nodes than slots ever used")
    `CLCE_ASSERT_IMPL(a_empty_ptrs_zero, empty,
        tail_reg == '0 && cursor_reg == '0 && before_reg == '0, "empty list with stale pointers")
    `CLCE_ASSERT_IMPL(a_count_hold, !$past(cmd.fin), $stable(count_reg),
        "node count moved outside finish step")
    `CLCE_ASSERT_IMPL(a_count_step, $past(cmd.fin),
        count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1 ||
        count_reg == $past(count_reg) - 1'b1, "node count moved by more than one")
    `CLCE_ASSERT_IMPL(a_result_from_finish, $rose(m_tvalid_reg), $past(cmd.fin),
        "result word appeared without a finish step")

endmodule
